>>> rtl/core/isc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants of the integral speed controller
// Field widths, register indexes and the structures that pass between the
// configuration registers, the update logic and the top level.
// ----------------------------------------------------------------------------
package isc_pkg;

	// Fraction bits of the scaled accumulator (Q17.16).
	localparam int FRAC_BITS = 16;

	typedef logic                motor_t;
	typedef logic signed [15:0] speed_t;
	typedef logic signed [16:0] drive_t;
	typedef logic        [23:0] gain_t;
	typedef logic        [15:0] limit_t;
	typedef logic signed [33:0] acc_t;
	typedef logic        [1:0]  cfg_idx_t;
	typedef logic        [23:0] cfg_data_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TARGET_FIRST  = 2'd0,
		REG_TARGET_SECOND = 2'd1,
		REG_INTEGRAL_GAIN = 2'd2,
		REG_DRIVE_LIMIT   = 2'd3
	} reg_idx_t;

	// Current contents of the configuration registers.
	typedef struct packed {
		speed_t target_first;
		speed_t target_second;
		gain_t  integral_gain;
		limit_t drive_limit;
	} cfg_t;

	// One speed sample held in the input stage.
	typedef struct packed {
		motor_t motor_index;
		speed_t measured_speed;
	} item_t;

	// Outcome of one accumulator update.
	typedef struct packed {
		logic   acc_we;
		logic   clear;
		acc_t   acc_next;
		drive_t drive;
	} step_res_t;

endpackage
`default_nettype wire

>>> rtl/core/isc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_if: request channels of the integral speed controller
// Valid/ready channels for speed samples and for drive results.
// ----------------------------------------------------------------------------
interface isc_in_if;
	logic            valid;
	logic            ready;
	isc_pkg::motor_t motor_index;
	isc_pkg::speed_t measured_speed;

	modport source(output valid, output motor_index, output measured_speed, input ready);
	modport sink(input valid, input motor_index, input measured_speed, output ready);
endinterface

interface isc_out_if;
	logic            valid;
	logic            ready;
	isc_pkg::motor_t result_motor;
	isc_pkg::drive_t drive_output;

	modport source(output valid, output result_motor, output drive_output, input ready);
	modport sink(input valid, input result_motor, input drive_output, output ready);
endinterface
`default_nettype wire

>>> rtl/core/isc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_cfg_regs: configuration registers
// Holds the two motor targets, the integral gain and the output limit.
// ----------------------------------------------------------------------------
module isc_cfg_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire isc_pkg::cfg_idx_t  cfg_index,
	input  wire isc_pkg::cfg_data_t cfg_data,
	output isc_pkg::cfg_t           cfg
);

	isc_pkg::cfg_t cfg_q;

	// Register writes; all registers reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (isc_pkg::reg_idx_t'(cfg_index))
				isc_pkg::REG_TARGET_FIRST: begin
					cfg_q.target_first <= isc_pkg::speed_t'(cfg_data[15:0]);
				end
				isc_pkg::REG_TARGET_SECOND: begin
					cfg_q.target_second <= isc_pkg::speed_t'(cfg_data[15:0]);
				end
				isc_pkg::REG_INTEGRAL_GAIN: begin
					cfg_q.integral_gain <= cfg_data;
				end
				isc_pkg::REG_DRIVE_LIMIT: begin
					cfg_q.drive_limit <= cfg_data[15:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/core/isc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_step: accumulator update for one speed sample
// Adds gain times error to the motor's accumulator, clamps the sum to the
// band given by the target's sign and takes the integer part as the drive.
// ----------------------------------------------------------------------------
module isc_step (
	input  wire isc_pkg::item_t  item,
	input  wire logic            motor_ok,
	input  wire isc_pkg::acc_t   acc_cur,
	input  wire isc_pkg::cfg_t   cfg,
	output isc_pkg::step_res_t   res
);

	localparam int SUM_W = 43;

	isc_pkg::speed_t          target;
	logic signed [16:0]       err;
	logic signed [41:0]       prod;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  lim;
	logic signed [SUM_W-1:0]  clamped;
	logic        [SUM_W-1:0]  mag;
	logic        [15:0]       int_mag;

	always_comb begin
		// Pick the target and form the error at 17 bits, so it cannot wrap.
		target  = item.motor_index ? cfg.target_second : cfg.target_first;
		err     = {target[15], target} - {item.measured_speed[15], item.measured_speed};
		prod    = $signed({1'b0, cfg.integral_gain}) * err;
		sum     = {{(SUM_W - 34){acc_cur[33]}}, acc_cur} + {prod[41], prod};
		lim     = $signed({11'b0, cfg.drive_limit, 16'b0});

		// Clamp to [0, limit] for a non-negative target, [-limit, 0] otherwise.
		if (!target[15]) begin
			if (sum > lim) begin
				clamped = lim;
			end else if (sum < 0) begin
				clamped = '0;
			end else begin
				clamped = sum;
			end
		end else begin
			if (sum < -lim) begin
				clamped = -lim;
			end else if (sum > 0) begin
				clamped = '0;
			end else begin
				clamped = sum;
			end
		end

		// Integer part, truncated toward zero; the magnitude stays below 2^32.
		mag     = clamped[SUM_W-1] ? SUM_W'(-clamped) : SUM_W'(clamped);
		int_mag = mag[isc_pkg::FRAC_BITS +: 16];

		res.clear    = (target == '0) || (cfg.integral_gain == '0);
		res.acc_we   = motor_ok;
		if (!motor_ok || res.clear) begin
			res.acc_next = '0;
			res.drive    = '0;
		end else begin
			res.acc_next = clamped[33:0];
			res.drive    = clamped[SUM_W-1] ? -$signed({1'b0, int_mag})
			                                : $signed({1'b0, int_mag});
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/integral_speed_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integral_speed_controller: pure-integral speed loop for several motors
// Speed samples come in on the sample channel (motor_index, measured_speed);
// one drive value per sample leaves on the drive channel (result_motor,
// drive_output), in sample order. Targets, gain and limit are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no sample
// is in flight, as the block does not enforce it. An accepted sample is
// captured in the input stage; then the motor's accumulator is updated and
// the result register is loaded, which offers the result. One sample is
// accepted per cycle while results are taken; the rate is set by the single
// multiply, add and clamp between the input stage and the result register.
// Reset clears the accumulators of all motors, the configuration registers
// and both valid flags; no clearing pass is needed.
// When the receiver stalls, the result waits in its register and one further
// sample may sit in the input stage; the sample channel then drops ready
// until the result is taken.
// ----------------------------------------------------------------------------
module integral_speed_controller #(
	parameter int MOTORS = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	isc_in_if.sink                  sample,
	isc_out_if.source               drive,
	input  wire logic               cfg_we,
	input  wire isc_pkg::cfg_idx_t  cfg_index,
	input  wire isc_pkg::cfg_data_t cfg_data
);

	isc_pkg::cfg_t      cfg;
	isc_pkg::item_t     item_s1;
	logic               valid_s1;
	isc_pkg::acc_t      acc_q [MOTORS];
	isc_pkg::acc_t      acc_cur;
	logic               motor_ok;
	logic               adv;
	logic [MOTORS-1:0]  acc_upd;
	isc_pkg::step_res_t st;
	logic               res_valid_q;
	isc_pkg::motor_t    res_motor_q;
	isc_pkg::drive_t    res_drive_q;

	isc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register moves when empty or when its request is taken.
	assign adv          = !res_valid_q || drive.ready;
	assign sample.ready = !valid_s1 || adv;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			item_s1.motor_index    <= sample.motor_index;
			item_s1.measured_speed <= sample.measured_speed;
		end
	end

	// Select the accumulator of the sample's motor.
	always_comb begin
		motor_ok = int'(item_s1.motor_index) < MOTORS;
		acc_cur  = '0;
		for (int i = 0; i < MOTORS; i++) begin
			if (int'(item_s1.motor_index) == i) begin
				acc_cur = acc_q[i];
			end
		end
	end

	isc_step u_step (
		.item     (item_s1),
		.motor_ok (motor_ok),
		.acc_cur  (acc_cur),
		.cfg      (cfg),
		.res      (st)
	);

	// Accumulator bank, one register per motor, written back as the result register loads.
	for (genvar i = 0; i < MOTORS; i++) begin : g_acc
		assign acc_upd[i] = adv && valid_s1 && st.acc_we && (int'(item_s1.motor_index) == i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[i] <= '0;
			end else if (acc_upd[i]) begin
				acc_q[i] <= st.acc_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_motor_q <= item_s1.motor_index;
			res_drive_q <= st.drive;
		end
	end

	assign drive.valid        = res_valid_q;
	assign drive.result_motor = res_motor_q;
	assign drive.drive_output = res_drive_q;

`ifndef SYNTH
	// A sample in the input stage reaches the result register when it moves.
	a_stage_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1) |=> res_valid_q)
		else $error("sample in input stage did not reach the result register");

	// Sample ready drops only with both stages full and the result stalled.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (valid_s1 && res_valid_q && !drive.ready))
		else $error("sample channel stalled without a stalled result");

	// A zero target or zero gain leaves the motor's accumulator cleared.
	for (genvar i = 0; i < MOTORS; i++) begin : g_chk
		a_clear: assert property (@(posedge clk) disable iff (!arst_n)
			(acc_upd[i] && st.clear) |=> (acc_q[i] == '0))
			else $error("accumulator not cleared on zero target or gain");
	end
`endif

endmodule
`default_nettype wire
